// File: rtl/lss_pkg.sv
// Shared types and constants for the latency sample statistics core.
`default_nettype none
package lss_pkg;

    localparam int PCT_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int FIELD_W     = 24;
    localparam int COUNT_OUT_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_HIGH_PCT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_PCT  = 2'd1;

    localparam logic [PCT_W-1:0] HIGH_PCT_RST = 7'd99;
    localparam logic [PCT_W-1:0] LOW_PCT_RST  = 7'd90;

    localparam logic [PCT_W-1:0] PCT_ROUND   = 7'd99;

    // floor(x / 100) = (x * ceil(2^32 / 100)) >> 32, exact for x < 2^30
    localparam int          PCT_RECIP_SH = 32;
    localparam logic [31:0] PCT_RECIP    = 32'd42949673;

    typedef struct packed {
        logic [FIELD_W-1:0] sample_value;
        logic               last_sample;
    } t_in_req;

    typedef struct packed {
        logic [FIELD_W-1:0]     upper_percentile;
        logic [FIELD_W-1:0]     lower_percentile;
        logic [FIELD_W-1:0]     mean_value;
        logic [FIELD_W-1:0]     std_deviation;
        logic [COUNT_OUT_W-1:0] sample_count;
        logic                   overflowed;
    } t_out_req;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PREP,
        ST_HI_DIV,
        ST_LO_DIV,
        ST_MEAN_DIV,
        ST_MUL,
        ST_VAR_DIV,
        ST_VAR_FIX,
        ST_SQRT,
        ST_SELECT,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

// File: rtl/latency_sample_statistics_core.sv
// Latency sample statistics core: percentiles, mean and stdev of a sample set.
//
//  channel   dir   handshake                      payload
//  -------   ---   ----------------------------   ------------------------
//  in        in    i_in_valid / o_in_ready        i_in_data  (t_in_req)
//  out       out   o_out_valid / i_out_ready      o_out_data (t_out_req)
//  cfg       in    i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// Loading accepts one request per cycle while the input is ready; the square
// of each kept sample is accumulated in the cycle after through a single
// SAMPLE_BITS by SAMPLE_BITS multiplier. After the last request the sequencer
// runs: the two ranks (reciprocal multiply by 1/100), two passes of a
// bit-serial divider, a shift-add multiply, a bit-pair square root and a
// radix select over the sample memory in SAMPLE_BITS passes.
// Input is not ready while the sequencer runs; a result waits in the
// output register. Reset is synchronous, active low; the memory is not
// cleared, only entries below the count are ever used.
`default_nettype none
module latency_sample_statistics_core #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire  lss_pkg::t_in_req            i_in_data,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output lss_pkg::t_out_req                 o_out_data,
    input  wire                               i_cfg_we,
    input  wire  [lss_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [lss_pkg::PCT_W-1:0]         i_cfg_data
);
    import lss_pkg::*;

    // widths
    localparam int AW      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_RAW = SAMPLE_BITS + CNT_W;
    localparam int SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;
    localparam int SQ_RAW  = 2 * SAMPLE_BITS + CNT_W;
    localparam int SQ_W    = (SQ_RAW > 64) ? 64 : SQ_RAW;
    localparam int DV_W    = (CNT_W > PCT_W) ? CNT_W : PCT_W;
    localparam int PX_W    = CNT_W + PCT_W;
    localparam int RT_H    = (SQ_W + 1) / 2;
    localparam int RT_W    = 2 * RT_H;
    localparam int BW      = $clog2(SAMPLE_BITS);
    localparam int CW      = $clog2(SQ_W + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    // state
    t_state r_state, n_state;
    logic [PCT_W-1:0]       r_high_pct, r_low_pct;
    logic [SAMPLE_BITS-1:0] r_mem [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] r_rd;
    logic                   r_rd_v;
    logic [CNT_W-1:0]       r_count;
    logic [SUM_W-1:0]       r_sum;
    logic [SQ_W-1:0]        r_sqsum;
    logic [SAMPLE_BITS-1:0] r_sqv;
    logic                   r_sq_pend;
    logic                   r_drop;

    // shared divider
    logic [SQ_W-1:0]        r_dq;
    logic [DV_W-1:0]        r_dr, r_dd;
    logic [CW-1:0]          r_cnt;

    // derived values
    logic [CNT_W-1:0]       r_k_hi, r_k_lo, r_s, r_b;
    logic [SAMPLE_BITS-1:0] r_m, r_mq;
    logic [SQ_W-1:0]        r_mcand, r_macc, r_a;
    logic [RT_W-1:0]        r_x, r_res, r_sbit;
    logic [RT_H-1:0]        r_sd;

    // selection
    logic [BW-1:0]          r_bit;
    logic [SAMPLE_BITS-1:0] r_pre_hi, r_pre_lo;
    logic [CNT_W-1:0]       r_c_hi, r_c_lo, r_addr;
    logic                   r_out_valid;
    t_out_req               r_out;

    // ---------------- combinational datapath ----------------
    logic                   in_acc;
    logic [63:0]            in_wide;
    logic [SAMPLE_BITS-1:0] in_v;
    logic [DV_W:0]          div_sh, div_rem;
    logic                   div_ge;
    logic [SQ_W-1:0]        div_q;
    logic                   div_last, mul_last, sqrt_last, pass_end;
    logic [PX_W+31:0]       pct_prod;
    logic [PX_W-1:0]        rank_q;
    logic [CNT_W-1:0]       rank_c;
    logic [SQ_W-1:0]        mul_acc_n, var_d;
    logic [2*CNT_W-1:0]     prod_nb, prod_ss;
    logic [RT_W-1:0]        rt_t, rt_x_n, rt_res_n;
    logic                   rt_ge;
    logic [SAMPLE_BITS-1:0] sel_above, sel_onehot;
    logic                   match_hi, match_lo;
    logic [63:0]            w_hi, w_lo, w_mean, w_sd, w_cnt;

    assign in_acc  = i_in_valid && o_in_ready;
    assign in_wide = 64'(i_in_data.sample_value);
    assign in_v    = in_wide[SAMPLE_BITS-1:0];

    // restoring divide, one quotient bit per cycle
    assign div_sh  = {r_dr, r_dq[SQ_W-1]};
    assign div_ge  = div_sh >= {1'b0, r_dd};
    assign div_rem = div_ge ? (div_sh - {1'b0, r_dd}) : div_sh;
    assign div_q   = {r_dq[SQ_W-2:0], div_ge};

    assign div_last  = r_cnt == CW'(SQ_W - 1);
    assign mul_last  = r_cnt == CW'(SAMPLE_BITS - 1);
    assign sqrt_last = r_cnt == CW'(RT_H - 1);
    assign pass_end  = (r_addr == r_count) && !r_rd_v;

    // rank = (n*pct + 99) / 100 through the reciprocal
    assign pct_prod = (PX_W+32)'(r_dq[PX_W-1:0]) * (PX_W+32)'(PCT_RECIP);
    assign rank_q   = pct_prod[PX_W+PCT_RECIP_SH-1:PCT_RECIP_SH];

    // rank clamped to 1..n
    always_comb begin
        if (rank_q == '0) begin
            rank_c = CNT_W'(1);
        end else if (rank_q > PX_W'(r_count)) begin
            rank_c = r_count;
        end else begin
            rank_c = rank_q[CNT_W-1:0];
        end
    end

    // shift-add: m * (S + s), MSB of m first
    assign mul_acc_n = (r_macc << 1) + (r_mq[SAMPLE_BITS-1] ? r_mcand : '0);
    assign var_d     = r_sqsum - mul_acc_n;

    assign prod_nb = (2*CNT_W)'(r_count) * (2*CNT_W)'(r_b);
    assign prod_ss = (2*CNT_W)'(r_s) * (2*CNT_W)'(r_s);

    // integer square root, one bit pair per cycle
    assign rt_t     = r_res + r_sbit;
    assign rt_ge    = r_x >= rt_t;
    assign rt_x_n   = rt_ge ? (r_x - rt_t) : r_x;
    assign rt_res_n = rt_ge ? ((r_res >> 1) + r_sbit) : (r_res >> 1);

    // radix select: count samples with the decided prefix and a zero here
    assign sel_above  = ({SAMPLE_BITS{1'b1}} << r_bit) << 1;
    assign sel_onehot = SAMPLE_BITS'(1) << r_bit;
    assign match_hi   = (((r_rd ^ r_pre_hi) & sel_above) == '0) && ((r_rd & sel_onehot) == '0);
    assign match_lo   = (((r_rd ^ r_pre_lo) & sel_above) == '0) && ((r_rd & sel_onehot) == '0);

    assign w_hi   = 64'(r_pre_hi);
    assign w_lo   = 64'(r_pre_lo);
    assign w_mean = 64'(r_m);
    assign w_sd   = 64'(r_sd);
    assign w_cnt  = 64'(r_count);

    assign o_in_ready  = r_state == ST_LOAD;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:     if (in_acc && i_in_data.last_sample) n_state = ST_PREP;
            ST_PREP:     n_state = ST_HI_DIV;
            ST_HI_DIV:   n_state = ST_LO_DIV;
            ST_LO_DIV:   n_state = ST_MEAN_DIV;
            ST_MEAN_DIV: if (div_last) n_state = ST_MUL;
            ST_MUL:      if (mul_last) n_state = ST_VAR_DIV;
            ST_VAR_DIV:  if (div_last) n_state = ST_VAR_FIX;
            ST_VAR_FIX:  n_state = ST_SQRT;
            ST_SQRT:     if (sqrt_last) n_state = ST_SELECT;
            ST_SELECT:   if (pass_end && r_bit == '0) n_state = ST_OUT;
            ST_OUT:      if (!r_out_valid) n_state = ST_LOAD;
            default:     n_state = ST_LOAD;
        endcase
    end

    // ---------------- config ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_pct <= HIGH_PCT_RST;
            r_low_pct  <= LOW_PCT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_HIGH_PCT) r_high_pct <= i_cfg_data;
            if (i_cfg_idx == REG_LOW_PCT)  r_low_pct  <= i_cfg_data;
        end
    end

    // ---------------- sample memory ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc && r_count != MAX_CNT) begin
            r_mem[r_count[AW-1:0]] <= in_v;
        end
        r_rd <= r_mem[r_addr[AW-1:0]];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_sqsum     <= '0;
            r_sq_pend   <= 1'b0;
            r_drop      <= 1'b0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sq_pend <= 1'b0;
            if (r_sq_pend) begin
                r_sqsum <= r_sqsum + SQ_W'(64'(r_sqv) * 64'(r_sqv));
            end
            if (in_acc) begin
                if (r_count != MAX_CNT) begin
                    r_count   <= r_count + 1'b1;
                    r_sum     <= r_sum + SUM_W'(in_v);
                    r_sq_pend <= 1'b1;
                end else begin
                    r_drop <= 1'b1;
                end
            end
            r_rd_v <= (r_state == ST_SELECT) && (r_addr != r_count);
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_OUT && !r_out_valid) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_sum       <= '0;
                r_sqsum     <= '0;
                r_drop      <= 1'b0;
            end
        end
    end

    // ---------------- arithmetic datapath ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sqv <= in_v;
        end
        case (r_state)
            ST_PREP: begin
                r_dq <= SQ_W'(r_count) * SQ_W'(r_high_pct) + SQ_W'(PCT_ROUND);
            end
            ST_HI_DIV: begin
                r_k_hi <= rank_c;
                r_dq   <= SQ_W'(r_count) * SQ_W'(r_low_pct) + SQ_W'(PCT_ROUND);
            end
            ST_LO_DIV: begin
                r_k_lo <= rank_c;
                r_dq   <= SQ_W'(r_sum);
                r_dr   <= '0;
                r_dd   <= DV_W'(r_count);
                r_cnt  <= '0;
            end
            ST_MEAN_DIV, ST_VAR_DIV: begin
                r_dq  <= div_q;
                r_dr  <= div_rem[DV_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (div_last) begin
                    r_cnt <= '0;
                    r_dr  <= '0;
                    if (r_state == ST_MEAN_DIV) begin
                        r_m     <= div_q[SAMPLE_BITS-1:0];
                        r_mq    <= div_q[SAMPLE_BITS-1:0];
                        r_s     <= div_rem[CNT_W-1:0];
                        r_mcand <= SQ_W'(r_sum) + SQ_W'(div_rem[CNT_W-1:0]);
                        r_macc  <= '0;
                    end else begin
                        r_a <= div_q;
                        r_b <= div_rem[CNT_W-1:0];
                    end
                end
            end
            ST_MUL: begin
                r_macc <= mul_acc_n;
                r_mq   <= r_mq << 1;
                r_cnt  <= r_cnt + 1'b1;
                if (mul_last) begin
                    r_cnt <= '0;
                    r_dq  <= var_d;
                    r_dr  <= '0;
                    r_dd  <= DV_W'(r_count);
                end
            end
            ST_VAR_FIX: begin
                // floor of (nQ - S^2)/n^2 is one below d/n when n*b < s^2
                r_x    <= (prod_nb < prod_ss) ? RT_W'(r_a - 1'b1) : RT_W'(r_a);
                r_res  <= '0;
                r_sbit <= RT_W'(1) << (RT_W - 2);
                r_cnt  <= '0;
            end
            ST_SQRT: begin
                r_x    <= rt_x_n;
                r_res  <= rt_res_n;
                r_sbit <= r_sbit >> 2;
                r_cnt  <= r_cnt + 1'b1;
                if (sqrt_last) begin
                    r_sd     <= rt_res_n[RT_H-1:0];
                    r_bit    <= BW'(SAMPLE_BITS - 1);
                    r_pre_hi <= '0;
                    r_pre_lo <= '0;
                    r_c_hi   <= '0;
                    r_c_lo   <= '0;
                    r_addr   <= '0;
                end
            end
            ST_SELECT: begin
                if (r_addr != r_count) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (r_rd_v) begin
                    r_c_hi <= r_c_hi + CNT_W'(match_hi);
                    r_c_lo <= r_c_lo + CNT_W'(match_lo);
                end
                if (pass_end) begin
                    if (r_k_hi > r_c_hi) begin
                        r_pre_hi <= r_pre_hi | sel_onehot;
                        r_k_hi   <= r_k_hi - r_c_hi;
                    end
                    if (r_k_lo > r_c_lo) begin
                        r_pre_lo <= r_pre_lo | sel_onehot;
                        r_k_lo   <= r_k_lo - r_c_lo;
                    end
                    r_c_hi <= '0;
                    r_c_lo <= '0;
                    r_addr <= '0;
                    r_bit  <= r_bit - 1'b1;
                end
            end
            ST_OUT: begin
                if (!r_out_valid) begin
                    r_out.upper_percentile <= w_hi[FIELD_W-1:0];
                    r_out.lower_percentile <= w_lo[FIELD_W-1:0];
                    r_out.mean_value       <= w_mean[FIELD_W-1:0];
                    r_out.std_deviation    <= w_sd[FIELD_W-1:0];
                    r_out.sample_count     <= w_cnt[COUNT_OUT_W-1:0];
                    r_out.overflowed       <= r_drop;
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("sample count beyond capacity");

    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.last_sample) |=> !o_in_ready)
        else $error("input ready after last request");

    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SELECT) |-> (r_k_hi >= CNT_W'(1) && r_k_lo >= CNT_W'(1)))
        else $error("select rank out of range");

    a_out_after_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("result raised outside output state");
`endif

endmodule
`default_nettype wire

// File: tb/sv/latency_sample_statistics_core_tb.sv
// Self-checking testbench for the latency sample statistics core.
`timescale 1ns / 1ps
`default_nettype none
module latency_sample_statistics_core_tb;
    import lss_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int RANDOM_ITEMS = 600;
    // indexes past the two real registers, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic i_clk = 1'b1;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in_req in_data = '0;
    logic out_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [PCT_W-1:0] cfg_data = '0;
    logic o_in_ready, o_out_valid;
    t_out_req o_out_data;

    latency_sample_statistics_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // pending requests for the driver, expected statistics for the monitor
    t_in_req  pend_q[$];
    t_out_req stats_due[$];

    // mirror of the block's set state and percent registers
    logic [FIELD_W-1:0] set_q[$];
    longint unsigned acc_sum, acc_sq;
    bit acc_dropped;
    logic [PCT_W-1:0] hi_pct = HIGH_PCT_RST;
    logic [PCT_W-1:0] lo_pct = LOW_PCT_RST;

    int  mismatches = 0;
    int  results_seen = 0;
    int  accepted = 0;
    int  overflow_sets = 0;
    bit  in_acc = 0;       // request accepted at the last rising edge
    bit  quiet = 0;        // no idling in the closing phase
    bit  rx_hold = 0;      // long receiver hold-off
    int  gap_in = 0, gap_out = 0;

    function automatic longint unsigned isqrt_floor(longint unsigned x);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [FIELD_W-1:0] rank_pick(ref logic [FIELD_W-1:0] srt[$],
                                                     input logic [PCT_W-1:0] pct);
        longint unsigned rank;
        rank = (longint'(srt.size()) * pct + 99) / 100;
        if (rank < 1) rank = 1;
        if (rank > srt.size()) rank = srt.size();
        return srt[rank - 1];
    endfunction

    // fold one request into the set; on the last one, queue the statistics
    function automatic void absorb_sample(t_in_req r);
        logic [FIELD_W-1:0] srt[$];
        longint unsigned n, m, s, d, a, b, var_q, root;
        t_out_req e;
        if (set_q.size() < STORE_DEPTH) begin
            set_q.push_back(r.sample_value);
            acc_sum += r.sample_value;
            acc_sq += longint'(r.sample_value) * longint'(r.sample_value);
        end else begin
            acc_dropped = 1;
        end
        if (!r.last_sample) return;
        n = set_q.size();
        srt = set_q;
        srt.sort();
        // exact floor variance: n*Q - S^2 split around the mean
        m = acc_sum / n;
        s = acc_sum % n;
        d = acc_sq - n * m * m - 2 * m * s;
        a = d / n;
        b = d % n;
        var_q = (n * b < s * s) ? a - 1 : a;
        root = isqrt_floor(var_q);
        e.upper_percentile = rank_pick(srt, hi_pct);
        e.lower_percentile = rank_pick(srt, lo_pct);
        e.mean_value       = m[FIELD_W-1:0];
        e.std_deviation    = root[FIELD_W-1:0];
        e.sample_count     = n[COUNT_OUT_W-1:0];
        e.overflowed       = acc_dropped;
        if (acc_dropped) overflow_sets++;
        stats_due.push_back(e);
        set_q.delete();
        acc_sum = 0;
        acc_sq = 0;
        acc_dropped = 0;
    endfunction

    // monitor: sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_out_req e;
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                absorb_sample(in_data);
                accepted++;
                in_acc = 1;
            end
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (stats_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", o_out_data);
                end else begin
                    e = stats_due.pop_front();
                    if (o_out_data !== e) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %p got %p", e, o_out_data);
                    end
                end
            end
        end
    end

    // driver and receiver: change inputs at the falling edge
    always @(negedge i_clk) begin
        if (in_acc) begin
            in_valid = 1'b0;
            in_acc = 0;
        end
        if (i_rst_n && !in_valid) begin
            if (gap_in > 0) begin
                gap_in--;
            end else if (pend_q.size() != 0) begin
                if (!quiet && $urandom_range(0, 11) == 0) begin
                    gap_in = $urandom_range(1, 18) - 1;
                end else begin
                    in_data = pend_q.pop_front();
                    in_valid = 1'b1;
                end
            end
        end
        if (!i_rst_n || rx_hold) begin
            out_ready = 1'b0;
        end else if (gap_out > 0) begin
            gap_out--;
            out_ready = 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            gap_out = $urandom_range(1, 18) - 1;
            out_ready = 1'b0;
        end else begin
            out_ready = 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PCT_W-1:0] val);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = val;
        if (idx == REG_HIGH_PCT) hi_pct = val;
        else if (idx == REG_LOW_PCT) lo_pct = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // block is idle once every request is in and every result is out
    task automatic drain();
        while (pend_q.size() != 0 || in_valid || stats_due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [FIELD_W-1:0] pick_value(logic [FIELD_W-1:0] prev);
        case ($urandom_range(0, 4))
            0: return FIELD_W'($urandom_range(0, 255));
            1: return FIELD_W'(24'hFFFF00 | $urandom_range(0, 255));
            2: return prev;
            default: return FIELD_W'($urandom());
        endcase
    endfunction

    task automatic queue_set(int n, int mode);
        t_in_req r;
        logic [FIELD_W-1:0] v;
        v = '0;
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: v = pick_value(v);
                1: v = '1;
                default: v = '0;
            endcase
            r.sample_value = v;
            r.last_sample = (i == n - 1);
            pend_q.push_back(r);
        end
    endtask

    task automatic hold_receiver(int cycles);
        rx_hold = 1;
        repeat (cycles) @(posedge i_clk);
        rx_hold = 0;
    endtask

    initial begin
        logic [PCT_W-1:0] hi_list[7] = '{7'd100, 7'd0, 7'd50, 7'd1, 7'd37, 7'd127, 7'd99};
        logic [PCT_W-1:0] lo_list[7] = '{7'd1, 7'd127, 7'd50, 7'd100, 7'd73, 7'd0, 7'd90};
        int rnd_items;
        int n;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: single samples at the extremes, short mixed sets
        queue_set(1, 2);
        queue_set(1, 1);
        queue_set(2, 0);
        queue_set(5, 0);
        drain();
        write_reg(REG_HIGH_PCT, 7'd100);
        write_reg(REG_LOW_PCT, 7'd1);
        queue_set(7, 0);
        drain();
        // percent zero clamps to rank one, above hundred to the top rank
        write_reg(REG_HIGH_PCT, 7'd0);
        write_reg(REG_LOW_PCT, 7'd127);
        queue_set(4, 0);
        drain();
        // writes to unused indexes must leave the percents alone
        write_reg(REG_SPARE_A, 7'd5);
        write_reg(REG_SPARE_B, 7'd60);
        queue_set(3, 0);
        drain();
        // full store of maximum values, then a set past capacity
        queue_set(STORE_DEPTH, 1);
        drain();
        queue_set(STORE_DEPTH + 6, 0);
        drain();

        // random sets over several percent settings
        rnd_items = 0;
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(REG_HIGH_PCT, hi_list[ph]);
            write_reg(REG_LOW_PCT, lo_list[ph]);
            quiet = (ph == 6);
            if (ph == 2) fork hold_receiver(3000); join_none
            for (int k = 0; k < RANDOM_ITEMS / 7; k += n) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                : $urandom_range(1, 20);
                queue_set(n, 0);
                rnd_items += n;
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("covered %0d requests, %0d results, %0d with overflow, %0d random requests",
                 accepted, results_seen, overflow_sets, rnd_items);
        if (mismatches == 0 && stats_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("mismatches %0d, results still due %0d", mismatches, stats_due.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("timeout, results still due %0d", stats_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
